### src/assert_macros.svh
// Assertion macros shared by the checker of the saccade detector.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define GSD_ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define GSD_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// next-cycle implication, checked during reset too
`define GSD_ASSERT_ALWAYS_NEXT(lbl, clk, a, b) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

`endif

### src/gsd_pkg.sv
// Types and constants of the gaze saccade detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package gsd_pkg;
   localparam int unsigned COORD_BITS = 24;
   localparam int unsigned TIME_BITS  = 32;
   localparam int unsigned OUT_BITS   = 24;
   localparam int unsigned CSR_BITS   = 4;
   localparam int unsigned VEL_SCALE  = 1000000;
   localparam int unsigned ACC_SCALE  = 2000000;

   localparam logic [CSR_BITS-1:0] CSR_VELOCITY_LIMIT = 4'd0;
   localparam logic [CSR_BITS-1:0] CSR_ACCEL_LIMIT    = 4'd1;

   localparam logic [1:0] PH_V1  = 2'd0;
   localparam logic [1:0] PH_V2  = 2'd1;
   localparam logic [1:0] PH_ACC = 2'd2;

   typedef struct packed {
      logic                  clear;
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-1:0] bx;
      logic [COORD_BITS-1:0] by;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [TIME_BITS-1:0]  dt1;
      logic [TIME_BITS-1:0]  dt2;
      logic [OUT_BITS-1:0]   index;
   } job_type;

   typedef struct packed {
      logic    push;
      logic    pop;
      job_type job;
   } queue_ctl_type;

   typedef enum logic [3:0] {
      B_IDLE, B_SQX, B_SQY, B_ROOT, B_SCALE, B_DIVSET, B_DIV, B_DIVEND,
      B_ACCEL, B_DECIDE, B_OUT
   } back_state_type;
endpackage
`default_nettype wire

### src/gaze_saccade_detector.sv
// Top level of the gaze saccade detector: limit registers, front end,
// job queue and back end. Uses gsd_pkg, gsd_front, gsd_queue, gsd_back.
`timescale 1ns / 1ps
`default_nettype none
// A sample that forms no window with positive steps queues no job. A
// sample that does queues a job for the back end, whose divides skip their
// bit steps when they saturate. The back end takes the job, then for each
// of the two steps squares the x and y steps, runs the bit-serial square
// root, does a scaling multiply, sets up the divider, runs the
// one-bit-per-cycle divider and stores the speed. Then it divides for the
// acceleration and decides. A flagged sample's result is held until it is
// accepted. The two-entry job queue lets the front end take samples while
// the back end works and a result waits; with both entries taken the front
// end stalls every request.
module gaze_saccade_detector import gsd_pkg::*; #(
   parameter int unsigned INDEX_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_sample_x,
   input  wire logic [COORD_BITS-1:0] req_sample_y,
   input  wire logic [TIME_BITS-1:0]  req_sample_time_us,
   input  wire logic                  req_new_sequence,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [OUT_BITS-1:0]        rsp_saccade_index,
   output logic [OUT_BITS-1:0]        rsp_saccade_total,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_BITS-1:0]   csr_index,
   input  wire logic [31:0]           csr_wdata
);
   logic [31:0]   velocity_limit_ff, acceleration_limit_ff;
   queue_ctl_type qctl;
   logic          queue_full, head_valid, queue_push, queue_pop;
   job_type       head, queue_job;

   assign qctl.push = queue_push;
   assign qctl.pop  = queue_pop;
   assign qctl.job  = queue_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_limit_ff     <= 32'd19660800;
         acceleration_limit_ff <= 32'd32768000;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_VELOCITY_LIMIT: velocity_limit_ff     <= csr_wdata;
            CSR_ACCEL_LIMIT:    acceleration_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   gsd_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_sample_x, .req_sample_y,
      .req_sample_time_us, .req_new_sequence, .queue_full,
      .push(queue_push), .push_job(queue_job)
   );

   gsd_queue u_queue (
      .clock, .reset, .ctl(qctl), .full(queue_full), .head_valid, .head
   );

   gsd_back u_back (
      .clock, .reset, .job_valid(head_valid), .job(head), .job_pop(queue_pop),
      .velocity_limit(velocity_limit_ff), .acceleration_limit(acceleration_limit_ff),
      .rsp_valid, .rsp_stall, .rsp_saccade_index, .rsp_saccade_total
   );
endmodule
`default_nettype wire

### src/gsd_front.sv
// Front end: takes gaze samples, keeps the window and the sample index,
// and queues a job for each window with positive steps. Uses gsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsd_front import gsd_pkg::*; #(
   parameter int unsigned INDEX_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_sample_x,
   input  wire logic [COORD_BITS-1:0] req_sample_y,
   input  wire logic [TIME_BITS-1:0]  req_sample_time_us,
   input  wire logic                  req_new_sequence,
   input  wire logic                  queue_full,
   output logic                       push,
   output job_type                    push_job
);
   logic [COORD_BITS-1:0] older_x_ff, older_y_ff, middle_x_ff, middle_y_ff;
   logic [TIME_BITS-1:0]  older_time_ff, middle_time_ff;
   logic [1:0]            held_ff, held_eff;
   logic [INDEX_BITS-1:0] counter_ff, counter_eff, mid_index;
   logic [31:0]           mid_wide;
   logic                  pending_ff, pending_in, accept, window;

   assign req_stall   = queue_full;
   assign accept      = req_valid && !req_stall;
   assign held_eff    = req_new_sequence ? 2'd0 : held_ff;
   assign counter_eff = req_new_sequence ? '0 : counter_ff;
   assign window      = (held_eff == 2'd2) && (middle_time_ff > older_time_ff)
                        && (req_sample_time_us > middle_time_ff);
   assign push        = accept && window;
   assign mid_index   = counter_eff - INDEX_BITS'(1);
   assign mid_wide    = 32'(mid_index);

   always_comb begin
      push_job.clear = pending_ff || req_new_sequence;
      push_job.ax    = older_x_ff;
      push_job.ay    = older_y_ff;
      push_job.bx    = middle_x_ff;
      push_job.by    = middle_y_ff;
      push_job.cx    = req_sample_x;
      push_job.cy    = req_sample_y;
      push_job.dt1   = middle_time_ff - older_time_ff;
      push_job.dt2   = req_sample_time_us - middle_time_ff;
      push_job.index = mid_wide[OUT_BITS-1:0];
      pending_in     = pending_ff;
      if (req_new_sequence) begin
         pending_in = 1'b1;
      end else if (push) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= 2'd0;
         counter_ff     <= '0;
         pending_ff     <= 1'b0;
         older_x_ff     <= '0;
         older_y_ff     <= '0;
         older_time_ff  <= '0;
         middle_x_ff    <= '0;
         middle_y_ff    <= '0;
         middle_time_ff <= '0;
      end else if (accept) begin
         held_ff        <= (held_eff == 2'd2) ? 2'd2 : held_eff + 2'd1;
         counter_ff     <= counter_eff + INDEX_BITS'(1);
         pending_ff     <= pending_in;
         older_x_ff     <= middle_x_ff;
         older_y_ff     <= middle_y_ff;
         older_time_ff  <= middle_time_ff;
         middle_x_ff    <= req_sample_x;
         middle_y_ff    <= req_sample_y;
         middle_time_ff <= req_sample_time_us;
      end
   end
endmodule
`default_nettype wire

### src/gsd_queue.sv
// Two-entry job queue between front and back end. Uses gsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsd_queue import gsd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_ctl_type ctl,
   output logic              full,
   output logic              head_valid,
   output job_type           head
);
   job_type    entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] fill_ff;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[wr_ff] <= ctl.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (ctl.push) wr_ff <= !wr_ff;
         if (ctl.pop)  rd_ff <= !rd_ff;
         case ({ctl.push, ctl.pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end
endmodule
`default_nettype wire

### src/gsd_back.sv
// Back end: bit-serial square root and shared serial divider work out the
// speeds and acceleration of one window and emit saccades. Uses gsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsd_back import gsd_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   input  wire job_type             job,
   output logic                     job_pop,
   input  wire logic [31:0]         velocity_limit,
   input  wire logic [31:0]         acceleration_limit,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [OUT_BITS-1:0]      rsp_saccade_index,
   output logic [OUT_BITS-1:0]      rsp_saccade_total
);
   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [1:0]     phase_ff, phase_in;
   logic [49:0]    rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [63:0]    num_ff, num_in;
   logic [33:0]    rem_ff, rem_in, trial;
   logic [32:0]    den_ff, den_in;
   logic           sat_ff, sat_in, ge, hit;
   logic [4:0]     cnt_ff, cnt_in;
   logic [31:0]    v1_ff, v1_in, v2_ff, v2_in, quo, dv;
   logic [OUT_BITS-1:0] count_ff, count_in, base;
   logic [COORD_BITS-1:0] p, q;
   logic signed [24:0] diff;
   logic [24:0]    mag;
   logic [49:0]    square;
   logic [50:0]    rb;

   assign rsp_valid = (state_ff == B_OUT);

   always_comb begin
      if (phase_ff == PH_V1) begin
         p = (state_ff == B_SQX) ? job_ff.ax : job_ff.ay;
         q = (state_ff == B_SQX) ? job_ff.bx : job_ff.by;
      end else begin
         p = (state_ff == B_SQX) ? job_ff.bx : job_ff.by;
         q = (state_ff == B_SQX) ? job_ff.cx : job_ff.cy;
      end
      diff   = $signed({q[COORD_BITS-1], q}) - $signed({p[COORD_BITS-1], p});
      mag    = diff[24] ? 25'(-diff) : 25'(diff);
      square = 50'(mag) * 50'(mag);
      rb     = {1'b0, root_ff} + {1'b0, bit_ff};
      trial  = {rem_ff[32:0], num_ff[31]};
      ge     = trial >= {1'b0, den_ff};
      quo    = sat_ff ? 32'hFFFF_FFFF : num_ff[31:0];
      dv     = (v2_ff > v1_ff) ? v2_ff - v1_ff : v1_ff - v2_ff;
      hit    = (v1_ff > velocity_limit) || (v2_ff > velocity_limit)
               || (quo > acceleration_limit);
      base   = job_ff.clear ? '0 : count_ff;

      state_in = state_ff;
      phase_in = phase_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      sat_in   = sat_ff;
      cnt_in   = cnt_ff;
      v1_in    = v1_ff;
      v2_in    = v2_ff;
      count_in = count_ff;
      job_pop  = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               phase_in = PH_V1;
               state_in = B_SQX;
            end
         end
         B_SQX: begin
            rad_in   = square;
            state_in = B_SQY;
         end
         B_SQY: begin
            rad_in   = rad_ff + square;
            root_in  = '0;
            bit_in   = 50'd1 << 48;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            if ({14'd0, rad_ff} >= 64'(rb)) begin
               rad_in  = rad_ff - rb[49:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = B_SCALE;
         end
         B_SCALE: begin
            num_in   = 64'(root_ff[24:0]) * 64'(VEL_SCALE);
            den_in   = (phase_ff == PH_V1) ? {1'b0, job_ff.dt1} : {1'b0, job_ff.dt2};
            state_in = B_DIVSET;
         end
         B_ACCEL: begin
            num_in   = 64'(dv) * 64'(ACC_SCALE);
            den_in   = {1'b0, job_ff.dt1} + {1'b0, job_ff.dt2};
            phase_in = PH_ACC;
            state_in = B_DIVSET;
         end
         B_DIVSET: begin
            sat_in   = {1'b0, num_ff[63:32]} >= den_ff;
            rem_in   = {2'd0, num_ff[63:32]};
            cnt_in   = 5'd31;
            state_in = sat_in ? B_DIVEND : B_DIV;
         end
         B_DIV: begin
            rem_in        = ge ? trial - {1'b0, den_ff} : trial;
            num_in[31:0]  = {num_ff[30:0], ge};
            cnt_in        = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = B_DIVEND;
         end
         B_DIVEND: begin
            case (phase_ff)
               PH_V1: begin
                  v1_in    = quo;
                  phase_in = PH_V2;
                  state_in = B_SQX;
               end
               PH_V2: begin
                  v2_in    = quo;
                  state_in = B_ACCEL;
               end
               default: state_in = B_DECIDE;
            endcase
         end
         B_DECIDE: begin
            count_in = base;
            state_in = B_IDLE;
            if (hit) begin
               if (base != '1) count_in = base + OUT_BITS'(1);
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_stall) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job;
      phase_ff <= phase_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      sat_ff   <= sat_in;
      cnt_ff   <= cnt_in;
      v1_ff    <= v1_in;
      v2_ff    <= v2_in;
      if (state_ff == B_DECIDE) begin
         rsp_saccade_index <= job_ff.index;
         rsp_saccade_total <= count_in;
      end
   end
endmodule
`default_nettype wire

### src/gsd_checker.sv
// Port-level checks of the gaze saccade detector, bound to the top level.
// Uses gsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gsd_checker import gsd_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [OUT_BITS-1:0]   rsp_saccade_index,
   input wire logic [OUT_BITS-1:0]   rsp_saccade_total
);
   `GSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable({rsp_saccade_index, rsp_saccade_total}))
   `GSD_ASSERT_ALWAYS_NEXT(a_reset_quiet, clock, reset, !rsp_valid)
   `GSD_ASSERT_NOW(a_total_nonzero, clock, reset, rsp_valid, rsp_saccade_total != '0)
   `GSD_ASSERT_NEXT(a_one_result, clock, reset, rsp_valid && !rsp_stall, !rsp_valid)
endmodule
bind gaze_saccade_detector gsd_checker u_gsd_checker (.*);
`default_nettype wire

### tb/sv/gaze_saccade_checker.sv
// Checker for the gaze saccade detector: watches the request and response
// channels and the register port, predicts each flagged sample and compares.
// Depends on gsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gaze_saccade_checker import gsd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [COORD_BITS-1:0] req_sample_x,
   input  wire logic [COORD_BITS-1:0] req_sample_y,
   input  wire logic [TIME_BITS-1:0]  req_sample_time_us,
   input  wire logic                  req_new_sequence,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [OUT_BITS-1:0]   rsp_saccade_index,
   input  wire logic [OUT_BITS-1:0]   rsp_saccade_total,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_BITS-1:0]   csr_index,
   input  wire logic [31:0]           csr_wdata,
   output int                         fail_count,
   output int                         pending_count,
   output int                         checked_count
);
   typedef struct packed {
      logic [OUT_BITS-1:0] index;
      logic [OUT_BITS-1:0] total;
   } saccade_type;

   saccade_type saccade_queue[$];
   logic [31:0] vel_limit, acc_limit;
   logic [23:0] old_x, old_y, mid_x, mid_y;
   logic [31:0] old_t, mid_t;
   logic [1:0]  held;
   logic [23:0] sample_idx, total_ctr;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] gaze_speed(logic [23:0] ax, logic [23:0] ay,
         logic [23:0] bx, logic [23:0] by, logic [31:0] dt);
      longint dx, dy;
      logic [63:0] span, v;
      dx = longint'($signed(bx)) - longint'($signed(ax));
      dy = longint'($signed(by)) - longint'($signed(ay));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      span = int_sqrt(64'(dx * dx + dy * dy));
      v = span * 64'd1000000 / {32'd0, dt};
      return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   task automatic predict_sample(logic [23:0] nx, logic [23:0] ny, logic [31:0] nt,
         logic clr);
      logic [31:0] dt1, dt2, v1, v2;
      logic [63:0] dv, acc;
      saccade_type s;
      if (clr) begin
         held = 0;
         sample_idx = 0;
         total_ctr = 0;
      end
      if (held >= 2 && mid_t > old_t && nt > mid_t) begin
         dt1 = mid_t - old_t;
         dt2 = nt - mid_t;
         v1 = gaze_speed(old_x, old_y, mid_x, mid_y, dt1);
         v2 = gaze_speed(mid_x, mid_y, nx, ny, dt2);
         dv = v2 > v1 ? 64'(v2 - v1) : 64'(v1 - v2);
         acc = dv * 64'd2000000 / (64'(dt1) + 64'(dt2));
         if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
         if (v1 > vel_limit || v2 > vel_limit || acc[31:0] > acc_limit) begin
            if (total_ctr != 24'hFFFFFF) total_ctr++;
            s.index = sample_idx - 24'd1;
            s.total = total_ctr;
            saccade_queue.insert(saccade_queue.size(), s);
         end
      end
      old_x = mid_x; old_y = mid_y; old_t = mid_t;
      mid_x = nx; mid_y = ny; mid_t = nt;
      if (held < 2) held++;
      sample_idx++;
   endtask

   always @(posedge clock) begin
      saccade_type s;
      if (reset) begin
         vel_limit = 32'd19660800;
         acc_limit = 32'd32768000;
         {old_x, old_y, mid_x, mid_y, old_t, mid_t} = '0;
         held = 0; sample_idx = 0; total_ctr = 0;
         saccade_queue.delete();
         fail_count = 0;
         checked_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_VELOCITY_LIMIT) vel_limit = csr_wdata;
            else if (csr_index == CSR_ACCEL_LIMIT) acc_limit = csr_wdata;
         end
         if (req_valid && !req_stall)
            predict_sample(req_sample_x, req_sample_y, req_sample_time_us,
                           req_new_sequence);
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (saccade_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected saccade index %0d total %0d",
                           rsp_saccade_index, rsp_saccade_total);
            end else begin
               s = saccade_queue.pop_front();
               if (s.index !== rsp_saccade_index || s.total !== rsp_saccade_total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected index %0d total %0d, got %0d %0d",
                              s.index, s.total, rsp_saccade_index, rsp_saccade_total);
               end
            end
         end
      end
      pending_count = saccade_queue.size();
   end
endmodule
`default_nettype wire

### tb/sv/gaze_saccade_detector_test.sv
// Testbench top for the gaze saccade detector: clock, reset, request and
// register stimulus, response stall, verdict. Uses gsd_pkg and the checker.
`timescale 1ns / 1ps
`default_nettype none
module gaze_saccade_detector_test;
   import gsd_pkg::*;

   localparam logic [CSR_BITS-1:0] CSR_UNMAPPED = 4'hF;

   logic clock, reset;
   logic req_valid, req_stall, req_new_sequence;
   logic [COORD_BITS-1:0] req_sample_x, req_sample_y;
   logic [TIME_BITS-1:0]  req_sample_time_us;
   logic rsp_valid, rsp_stall;
   logic [OUT_BITS-1:0] rsp_saccade_index, rsp_saccade_total;
   logic csr_write_enable;
   logic [CSR_BITS-1:0] csr_index;
   logic [31:0] csr_wdata;
   int fail_count, pending_count, checked_count;
   bit hold_off;
   bit long_hold;
   int sent;
   logic [23:0] cur_x, cur_y;
   logic [31:0] cur_t;

   gaze_saccade_detector DUT (.*);
   gaze_saccade_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_sample(logic [23:0] x, logic [23:0] y, logic [31:0] t,
         logic ns);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 200) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_sample_x <= x;
      req_sample_y <= y;
      req_sample_time_us <= t;
      req_new_sequence <= ns;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic write_limit(logic [CSR_BITS-1:0] idx, logic [31:0] val);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // random walk: mostly small steps and increasing time, some jumps and noise
   task automatic random_sample();
      logic ns;
      int kind;
      ns = ($urandom_range(0, 60) == 0);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         cur_x = 24'($urandom); cur_y = 24'($urandom);
      end else if (kind < 4) begin
         cur_x = cur_x + 24'($signed($urandom_range(0, 200000)) - 100000);
         cur_y = cur_y + 24'($signed($urandom_range(0, 200000)) - 100000);
      end else begin
         cur_x = cur_x + 24'($signed($urandom_range(0, 2000)) - 1000);
         cur_y = cur_y + 24'($signed($urandom_range(0, 2000)) - 1000);
      end
      kind = $urandom_range(0, 29);
      if (kind == 0) cur_t = $urandom;
      else if (kind == 1) cur_t = cur_t - $urandom_range(0, 3);
      else if (kind == 2) cur_t = cur_t + $urandom_range(1, 5);
      else cur_t = cur_t + $urandom_range(500, 20000);
      send_sample(cur_x, cur_y, cur_t, ns);
   endtask

   initial begin
      int n;
      reset = 1;
      req_valid = 0;
      req_sample_x = 0; req_sample_y = 0; req_sample_time_us = 0;
      req_new_sequence = 0;
      csr_write_enable = 0; csr_index = 0; csr_wdata = 0;
      sent = 0;
      cur_x = 0; cur_y = 0; cur_t = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes, equal and backward time, wrapped time, new sequence
      send_sample(24'h800000, 24'h800000, 32'd0, 1'b1);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 32'd1, 1'b0);
      send_sample(24'h800000, 24'h7FFFFF, 32'd2, 1'b0);
      send_sample(24'h000000, 24'h000000, 32'd2, 1'b0);
      send_sample(24'h000001, 24'h000000, 32'd1, 1'b0);
      send_sample(24'h000002, 24'hFFFFFF, 32'd100000, 1'b0);
      send_sample(24'h000003, 24'h000000, 32'd200000, 1'b0);
      send_sample(24'h000003, 24'h000000, 32'hFFFF_FFFE, 1'b0);
      send_sample(24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, 1'b0);
      send_sample(24'h000000, 24'h000000, 32'h0000_0000, 1'b0);
      send_sample(24'h100000, 24'h000000, 32'd1000, 1'b1);
      send_sample(24'h100010, 24'h000000, 32'd11000, 1'b0);
      send_sample(24'h100020, 24'h000000, 32'd21000, 1'b0);
      send_sample(24'h300000, 24'h000000, 32'd31000, 1'b0);
      send_sample(24'h300010, 24'h000000, 32'd41000, 1'b0);
      write_limit(CSR_VELOCITY_LIMIT, 32'hFFFF_FFFF);
      write_limit(CSR_ACCEL_LIMIT, 32'hFFFF_FFFF);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 32'd0, 1'b1);
      send_sample(24'h800000, 24'h800000, 32'd1, 1'b0);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 32'd2, 1'b0);
      write_limit(CSR_VELOCITY_LIMIT, 32'd0);
      write_limit(CSR_ACCEL_LIMIT, 32'd0);
      send_sample(24'h000000, 24'h000000, 32'd10, 1'b0);
      send_sample(24'h000000, 24'h000000, 32'd20, 1'b0);
      write_limit(CSR_UNMAPPED, 32'hDEAD_BEEF);
      send_sample(24'h000001, 24'h000001, 32'd30, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_limit(CSR_VELOCITY_LIMIT, 32'd19660800);
               write_limit(CSR_ACCEL_LIMIT, 32'd32768000);
            end
            1: begin
               write_limit(CSR_VELOCITY_LIMIT, $urandom_range(1000000, 80000000));
               write_limit(CSR_ACCEL_LIMIT, $urandom);
            end
            2: begin
               write_limit(CSR_VELOCITY_LIMIT, 32'hFFFF_FFFF);
               write_limit(CSR_ACCEL_LIMIT, $urandom_range(1000000, 100000000));
            end
            3: begin
               write_limit(CSR_VELOCITY_LIMIT, 32'd0);
               write_limit(CSR_ACCEL_LIMIT, 32'hFFFF_FFFF);
            end
            default: begin
               write_limit(CSR_VELOCITY_LIMIT, $urandom);
               write_limit(CSR_ACCEL_LIMIT, $urandom);
            end
         endcase
         if (phase == 4) hold_off = 1;
         for (n = 0; n < 250; n++) random_sample();
      end
      req_valid <= 0;

      n = 0;
      while (pending_count != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (1000) @(posedge clock);
      $display("Sent %0d samples over directed cases and six threshold settings;",
               sent);
      $display("%0d saccade results were checked.", checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // one long response hold-off, counted in cycles
   initial begin
      long_hold = 0;
      wait (hold_off);
      @(posedge clock);
      long_hold <= 1;
      repeat (3000) @(posedge clock);
      long_hold <= 0;
   end

   // response stall: random short gaps, held high during the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (long_hold) begin
         rsp_stall <= 1;
      end else if (!rsp_stall) begin
         rsp_stall <= ($urandom_range(0, 15) == 0);
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 0;
      end
   end
endmodule
`default_nettype wire
